@@ rtl/core/paletted_packed_array_unpacker_top_assert.svh @@
// Assertion macros for the unpacker checker
`ifndef PALETTED_PACKED_ARRAY_UNPACKER_TOP_ASSERT_SVH
`define PALETTED_PACKED_ARRAY_UNPACKER_TOP_ASSERT_SVH

// Clocked check, off while reset is asserted
`define PPAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Clocked check that also holds during reset
`define PPAU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error("%m: check failed");

`endif

@@ rtl/core/ppau_pkg.sv @@
// Shared types, constants and tables of the paletted packed array unpacker
package ppau_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned SLOT_W      = 8;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned BPE_W       = 5;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned PLEN_W      = 9;
  localparam int unsigned PER_WORD_W  = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BPE_W-1:0]   BPE_RESET   = 5'd4;
  localparam logic [BPE_W-1:0]   BPE_MAX     = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;
  localparam logic [PLEN_W-1:0]  PLEN_RESET  = 9'd256;

  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_WORD    = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECT_MODE    = 2'd0,
    CFG_BITS_PER_ENTRY = 2'd1,
    CFG_ENTRY_COUNT    = 2'd2,
    CFG_PALETTE_LENGTH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                 direct_mode;
    logic [BPE_W-1:0]     bits_per_entry;
    logic [COUNT_W-1:0]   entry_count;
    logic [PLEN_W-1:0]    pal_len;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   pal_data;
    logic [WORD_W-1:0] word;
  } q_item_t;

  // Entries held by one word for a clamped width of 1..16
  function automatic logic [PER_WORD_W-1:0] per_word(input logic [BPE_W-1:0] w);
    logic [PER_WORD_W-1:0] n;
    unique case (w)
      5'd1:    n = 7'd64;
      5'd2:    n = 7'd32;
      5'd3:    n = 7'd21;
      5'd4:    n = 7'd16;
      5'd5:    n = 7'd12;
      5'd6:    n = 7'd10;
      5'd7:    n = 7'd9;
      5'd8:    n = 7'd8;
      5'd9:    n = 7'd7;
      5'd10:   n = 7'd6;
      5'd11:   n = 7'd5;
      5'd12:   n = 7'd5;
      default: n = 7'd4;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/core/paletted_packed_array_unpacker_top.sv @@
// Paletted packed array unpacker: top level with configuration registers.
// A data word yields one result per cycle while the output is not stalled,
// floor(64 / width) results in all (fewer when the section ends inside the
// word); a palette write makes no result. The rate is set by the single
// palette read port and the single output register, which take one entry
// each cycle. A two-entry queue lets the next transaction be taken while the
// current word is still unpacked.
module paletted_packed_array_unpacker_top #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned MAX_ENTRIES   = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [ppau_pkg::SLOT_W-1:0]       palette_slot_i,
  input  logic [ppau_pkg::ID_W-1:0]         palette_entry_i,
  input  logic [ppau_pkg::WORD_W-1:0]       packed_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ppau_pkg::ID_W-1:0]         entry_value_o,
  output logic [ppau_pkg::POS_W-1:0]        entry_position_o,
  output logic                              index_error_o,
  output logic                              last_in_word_o,
  output logic                              last_in_section_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ppau_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ppau_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  ppau_pkg::cfg_t    cfg_q;
  ppau_pkg::q_item_t head;
  logic              head_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direct_mode    <= 1'b0;
      cfg_q.bits_per_entry <= ppau_pkg::BPE_RESET;
      cfg_q.entry_count    <= ppau_pkg::COUNT_RESET;
      cfg_q.pal_len        <= ppau_pkg::PLEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ppau_pkg::cfg_idx_e'(cfg_index_i))
        ppau_pkg::CFG_DIRECT_MODE: begin
          cfg_q.direct_mode <= cfg_data_i[0];
        end
        ppau_pkg::CFG_BITS_PER_ENTRY: begin
          cfg_q.bits_per_entry <= cfg_data_i[ppau_pkg::BPE_W-1:0];
        end
        ppau_pkg::CFG_ENTRY_COUNT: begin
          cfg_q.entry_count <= cfg_data_i[ppau_pkg::COUNT_W-1:0];
        end
        ppau_pkg::CFG_PALETTE_LENGTH: begin
          cfg_q.pal_len <= cfg_data_i[ppau_pkg::PLEN_W-1:0];
        end
      endcase
    end
  end

  ppau_front #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .palette_slot_i  (palette_slot_i),
    .palette_entry_i (palette_entry_i),
    .packed_word_i   (packed_word_i),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .pop_i           (pop)
  );

  ppau_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .MAX_ENTRIES  (MAX_ENTRIES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .head_valid_i      (head_valid),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .entry_value_o     (entry_value_o),
    .entry_position_o  (entry_position_o),
    .index_error_o     (index_error_o),
    .last_in_word_o    (last_in_word_o),
    .last_in_section_o (last_in_section_o)
  );

endmodule

@@ rtl/core/ppau_front.sv @@
// Front end: accepts transactions, drops out-of-range palette writes, queues the rest
module ppau_front #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [ppau_pkg::SLOT_W-1:0]       palette_slot_i,
  input  logic [ppau_pkg::ID_W-1:0]         palette_entry_i,
  input  logic [ppau_pkg::WORD_W-1:0]       packed_word_i,
  output logic                              head_valid_o,
  output ppau_pkg::q_item_t                 head_o,
  input  logic                              pop_i
);

  localparam int unsigned Depth = ppau_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ppau_pkg::q_item_t item_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  ppau_pkg::q_item_t item;
  logic              drop, enq, deq;

  always_comb begin
    item.op       = ppau_pkg::op_e'(op_i);
    item.slot     = palette_slot_i;
    item.pal_data = palette_entry_i;
    item.word     = packed_word_i;
  end

  assign drop         = (item.op == ppau_pkg::OP_PALETTE) &&
                        (32'(palette_slot_i) >= 32'(PALETTE_DEPTH));
  assign in_ready_o   = (cnt_q != CntW'(Depth));
  assign enq          = in_valid_i && in_ready_o && !drop;
  assign head_valid_o = (cnt_q != '0);
  assign deq          = pop_i && head_valid_o;
  assign head_o       = item_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (enq) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (deq) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    priority if (enq && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (deq && !enq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      item_q[wptr_q] <= item;
    end
  end

endmodule

@@ rtl/core/ppau_back.sv @@
// Back end: palette store, per-entry extraction, lookup and output register
module ppau_back #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned MAX_ENTRIES   = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ppau_pkg::cfg_t                 cfg_i,
  input  logic                           head_valid_i,
  input  ppau_pkg::q_item_t              head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ppau_pkg::ID_W-1:0]      entry_value_o,
  output logic [ppau_pkg::POS_W-1:0]     entry_position_o,
  output logic                           index_error_o,
  output logic                           last_in_word_o,
  output logic                           last_in_section_o
);

  localparam int unsigned PalAw = $clog2(PALETTE_DEPTH);
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES);

  logic [ppau_pkg::ID_W-1:0] pal_mem [PALETTE_DEPTH];

  logic [ppau_pkg::BPE_W-1:0]      width;
  logic [ppau_pkg::COUNT_W-1:0]    eff_cnt;
  logic [ppau_pkg::ID_W-1:0]       mask;

  logic                            busy_q;
  logic [ppau_pkg::WORD_W-1:0]     word_q;
  logic [ppau_pkg::PER_WORD_W-1:0] rem_q;
  logic [CntW-1:0]                 cnt_q;

  logic                            head_word, head_pal, b_ready, issue, pal_wr;
  logic [ppau_pkg::WORD_W-1:0]     cur_word;
  logic [ppau_pkg::PER_WORD_W-1:0] cur_rem;
  logic [CntW-1:0]                 start_pos, cur_pos;
  logic [ppau_pkg::ID_W-1:0]       raw;
  logic                            sec_end, word_end, err;

  logic                            b_valid_q;
  logic [ppau_pkg::ID_W-1:0]       raw_q, rd_q;
  logic [ppau_pkg::POS_W-1:0]      pos_q;
  logic                            err_q, direct_q, lw_q, ls_q;

  always_comb begin
    priority if (cfg_i.bits_per_entry == '0) begin
      width = ppau_pkg::BPE_W'(1);
    end else if (cfg_i.bits_per_entry > ppau_pkg::BPE_MAX) begin
      width = ppau_pkg::BPE_MAX;
    end else begin
      width = cfg_i.bits_per_entry;
    end
    priority if (cfg_i.entry_count == '0) begin
      eff_cnt = ppau_pkg::COUNT_W'(1);
    end else if (32'(cfg_i.entry_count) > 32'(MAX_ENTRIES)) begin
      eff_cnt = ppau_pkg::COUNT_W'(MAX_ENTRIES);
    end else begin
      eff_cnt = cfg_i.entry_count;
    end
    mask = ppau_pkg::ID_W'((17'd1 << width) - 17'd1);
  end

  assign head_word = head_valid_i && (head_i.op == ppau_pkg::OP_WORD);
  assign head_pal  = head_valid_i && (head_i.op == ppau_pkg::OP_PALETTE);
  assign b_ready   = !b_valid_q || out_ready_i;
  assign issue     = (busy_q || head_word) && b_ready;
  assign pal_wr    = !busy_q && head_pal;
  assign pop_o     = pal_wr || (!busy_q && head_word && b_ready);

  assign start_pos = (32'(cnt_q) >= 32'(eff_cnt)) ? '0 : cnt_q;
  assign cur_word  = busy_q ? word_q : head_i.word;
  assign cur_rem   = busy_q ? rem_q : ppau_pkg::per_word(width);
  assign cur_pos   = busy_q ? cnt_q : start_pos;
  assign raw       = cur_word[ppau_pkg::ID_W-1:0] & mask;
  assign sec_end   = (32'(cur_pos) + 32'd1) >= 32'(eff_cnt);
  assign word_end  = sec_end || (cur_rem == ppau_pkg::PER_WORD_W'(1));
  assign err       = !cfg_i.direct_mode &&
                     ((32'(raw) >= 32'(cfg_i.pal_len)) ||
                      (32'(raw) >= 32'(PALETTE_DEPTH)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        busy_q <= !word_end;
        cnt_q  <= sec_end ? '0 : CntW'(32'(cur_pos) + 32'd1);
      end
      if (issue) begin
        b_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      word_q   <= cur_word >> width;
      rem_q    <= cur_rem - 1'b1;
      raw_q    <= raw;
      pos_q    <= ppau_pkg::POS_W'(cur_pos);
      err_q    <= err;
      direct_q <= cfg_i.direct_mode;
      lw_q     <= word_end;
      ls_q     <= sec_end;
      rd_q     <= pal_mem[raw[PalAw-1:0]];
    end
    if (pal_wr) begin
      pal_mem[PalAw'(head_i.slot)] <= head_i.pal_data;
    end
  end

  assign out_valid_o       = b_valid_q;
  assign entry_value_o     = err_q ? '0 : (direct_q ? raw_q : rd_q);
  assign entry_position_o  = pos_q;
  assign index_error_o     = err_q;
  assign last_in_word_o    = lw_q;
  assign last_in_section_o = ls_q;

endmodule

@@ rtl/core/ppau_checker.sv @@
// Port-level checker for the unpacker top level, with its bind
`include "paletted_packed_array_unpacker_top_assert.svh"

module ppau_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [ppau_pkg::ID_W-1:0]         entry_value_o,
  input logic [ppau_pkg::POS_W-1:0]        entry_position_o,
  input logic                              last_in_word_o,
  input logic                              last_in_section_o
);

  logic                       out_stall, mid_acc;
  logic [ppau_pkg::POS_W-1:0] pos_inc;

  assign out_stall = out_valid_o && !out_ready_i;
  assign mid_acc   = out_valid_o && out_ready_i && !last_in_word_o;
  assign pos_inc   = entry_position_o + 1'b1;

  // A stalled result stays offered
  `PPAU_ASSERT(a_out_hold, out_stall |=> out_valid_o)

  // A stalled result keeps its value and position
  `PPAU_ASSERT(a_out_stable, out_stall |=> $stable(entry_value_o) && $stable(entry_position_o))

  // Section end always closes the word
  `PPAU_ASSERT(a_sec_ends_word, out_valid_o && last_in_section_o |-> last_in_word_o)

  // Entries of one word come out at consecutive positions
  `PPAU_ASSERT(a_pos_step, mid_acc ##1 out_valid_o |-> entry_position_o == $past(pos_inc))

endmodule

bind paletted_packed_array_unpacker_top ppau_checker u_ppau_checker (.*);
